// ===== src/loop_or_single_progress_timer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Progress timer assertion macros
// Shared concurrent assertion wrappers, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LOOP_OR_SINGLE_PROGRESS_TIMER_CORE_MACROS_SVH
`define LOOP_OR_SINGLE_PROGRESS_TIMER_CORE_MACROS_SVH

// property must hold at every edge out of reset
`define LSPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen out of reset
`define LSPT_NEVER(label, cond, msg) \
   `LSPT_ASSERT(label, !(cond), msg)

`endif

// ===== src/lspt_pkg.sv =====
// ----------------------------------------------------------------------------
// Progress timer package
// Widths, operation and mode codes, and control bundles shared by the timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lspt_pkg;

   localparam int TIME_BITS       = 32;
   localparam int ALPHA_FRAC_BITS = 16;
   localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;
   localparam int ALPHA_STEPS     = ALPHA_FRAC_BITS + 1;

   localparam int DIV_STEPS_MAX = (TIME_BITS > ALPHA_STEPS) ? TIME_BITS : ALPHA_STEPS;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS_MAX + 1);
   localparam int ACC_CNT_W     = $clog2(TIME_BITS);

   localparam int OP_W   = 3;
   localparam int MODE_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = ((2 * TIME_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 + 2 * TIME_BITS + ALPHA_W + 7) / 8) * 8;

   localparam logic [ALPHA_W-1:0]   ALPHA_ONE  = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
   localparam logic [TIME_BITS-1:0] DUR_RESET  = TIME_BITS'(1000);

   // operation codes
   localparam logic [OP_W-1:0] OP_UPDATE  = 3'd0;
   localparam logic [OP_W-1:0] OP_RESET   = 3'd1;
   localparam logic [OP_W-1:0] OP_TOGGLE  = 3'd2;
   localparam logic [OP_W-1:0] OP_SETPAUSE = 3'd3;
   localparam logic [OP_W-1:0] OP_REWIND  = 3'd4;
   localparam logic [OP_W-1:0] OP_FFWD    = 3'd5;

   // timer modes
   localparam logic [MODE_W-1:0] MODE_INFINITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 1'd1;

   // accumulator pass kinds
   typedef enum logic [1:0] {
      ACC_KEEP  = 2'd0,
      ACC_ADD   = 2'd1,
      ACC_SUB   = 2'd2,
      ACC_CLEAR = 2'd3
   } acc_kind_type;

   typedef struct packed {
      logic         start;
      acc_kind_type kind;
      logic         use_delta;  // addend is now - previous, else amount
      logic         load_prev;  // previous time takes now
   } acc_cmd_type;

   typedef struct packed {
      logic start;
      logic loop_mode;          // run the remainder phase before alpha
   } div_cmd_type;

endpackage

`default_nettype wire

// ===== src/lspt_acc.sv =====
// ----------------------------------------------------------------------------
// Progress timer accumulator
// Bit-serial update of the accumulated time and previous time, LSB first,
// with a running compare of the new total against the duration.
// ----------------------------------------------------------------------------
`default_nettype none

module lspt_acc import lspt_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire acc_cmd_type          cmd,
   input  wire logic [TIME_BITS-1:0] now,
   input  wire logic [TIME_BITS-1:0] amount,
   input  wire logic [TIME_BITS-1:0] dur,
   output logic      [TIME_BITS-1:0] acc_value,
   output logic                      above_dur,
   output logic                      done
);

   logic [TIME_BITS-1:0] acc_ff, acc_in;
   logic [TIME_BITS-1:0] prev_ff, prev_in;
   logic [TIME_BITS-1:0] now_ff, amt_ff, dur_ff;
   acc_cmd_type          cmd_ff;
   logic [ACC_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic                 carry_ff, carry_in;
   logic                 dbor_ff, dbor_in;
   logic                 gt_ff, gt_in;
   logic                 a, p, n, du, dbit, b, s, last, sat, clr, gt_step;

   always_comb begin
      a    = acc_ff[0];
      p    = prev_ff[0];
      n    = now_ff[0];
      du   = dur_ff[0];
      last = (cnt_ff == '0);

      // serial now - previous
      dbit    = n ^ p ^ dbor_ff;
      dbor_in = (~n & p) | (~(n ^ p) & dbor_ff);

      b = cmd_ff.use_delta ? dbit : amt_ff[0];

      unique case (cmd_ff.kind)
         ACC_KEEP: begin
            s        = a;
            carry_in = 1'b0;
         end
         ACC_ADD: begin
            s        = a ^ b ^ carry_ff;
            carry_in = (a & b) | (a & carry_ff) | (b & carry_ff);
         end
         ACC_SUB: begin
            s        = a ^ b ^ carry_ff;
            carry_in = (~a & b) | (~(a ^ b) & carry_ff);
         end
         default: begin
            s        = 1'b0;
            carry_in = 1'b0;
         end
      endcase

      // saturate on carry out, clamp on borrow out
      sat = last & (cmd_ff.kind == ACC_ADD) & carry_in;
      clr = last & (cmd_ff.kind == ACC_SUB) & carry_in;

      gt_step = (s & ~du) | (gt_ff & ~(s ^ du));

      priority if (sat) begin
         acc_in = '1;
         gt_in  = ~&dur_ff;
      end else if (clr) begin
         acc_in = '0;
         gt_in  = 1'b0;
      end else begin
         acc_in = {s, acc_ff[TIME_BITS-1:1]};
         gt_in  = gt_step;
      end

      prev_in = {(cmd_ff.load_prev ? n : p), prev_ff[TIME_BITS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         prev_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ACC_CNT_W'(TIME_BITS - 1);
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            prev_ff <= prev_in;
            cnt_ff  <= cnt_ff - 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         now_ff   <= now;
         amt_ff   <= amount;
         dur_ff   <= dur;
         cmd_ff   <= cmd;
         carry_ff <= 1'b0;
         dbor_ff  <= 1'b0;
         gt_ff    <= 1'b0;
      end else if (busy_ff) begin
         now_ff   <= {1'b0, now_ff[TIME_BITS-1:1]};
         amt_ff   <= {1'b0, amt_ff[TIME_BITS-1:1]};
         dur_ff   <= {du, dur_ff[TIME_BITS-1:1]};
         carry_ff <= carry_in;
         dbor_ff  <= dbor_in;
         gt_ff    <= gt_in;
      end
   end

   assign acc_value = acc_ff;
   assign above_dur = gt_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

// ===== src/lspt_div.sv =====
// ----------------------------------------------------------------------------
// Progress timer divider
// Restoring divider, one quotient bit per cycle: remainder by the duration in
// loop mode, then the Q1.16 fraction of progression over duration.
// ----------------------------------------------------------------------------
`default_nettype none

module lspt_div import lspt_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire div_cmd_type          cmd,
   input  wire logic [TIME_BITS-1:0] numer,
   input  wire logic [TIME_BITS-1:0] prog_init,
   input  wire logic [TIME_BITS-1:0] dur,
   output logic      [TIME_BITS-1:0] prog,
   output logic      [ALPHA_W-1:0]   alpha,
   output logic                      done
);

   logic                 busy_ff, done_ff, mod_ph_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [TIME_BITS-1:0] r_ff, r_in, num_ff, dur_ff, prog_ff;
   logic [ALPHA_W-1:0]   q_ff;
   logic [TIME_BITS:0]   cand, diff;
   logic                 shift, in_bit, ge;

   always_comb begin
      // first alpha step compares progression itself, without a shift
      shift  = mod_ph_ff | (cnt_ff != DIV_CNT_W'(ALPHA_STEPS));
      in_bit = mod_ph_ff & num_ff[TIME_BITS-1];
      cand   = shift ? {r_ff, in_bit} : {1'b0, r_ff};
      diff   = cand - {1'b0, dur_ff};
      ge     = (cand >= {1'b0, dur_ff});
      r_in   = ge ? diff[TIME_BITS-1:0] : cand[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         mod_ph_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff   <= 1'b1;
            mod_ph_ff <= cmd.loop_mode;
            cnt_ff    <= cmd.loop_mode ? DIV_CNT_W'(TIME_BITS) : DIV_CNT_W'(ALPHA_STEPS);
         end else if (busy_ff) begin
            if (cnt_ff == DIV_CNT_W'(1)) begin
               if (mod_ph_ff) begin
                  mod_ph_ff <= 1'b0;
                  cnt_ff    <= DIV_CNT_W'(ALPHA_STEPS);
               end else begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dur_ff  <= dur;
         num_ff  <= numer;
         r_ff    <= cmd.loop_mode ? '0 : prog_init;
         prog_ff <= prog_init;
      end else if (busy_ff) begin
         r_ff   <= r_in;
         num_ff <= {num_ff[TIME_BITS-2:0], 1'b0};
         q_ff   <= {q_ff[ALPHA_W-2:0], ge};
         if (mod_ph_ff && (cnt_ff == DIV_CNT_W'(1))) begin
            prog_ff <= r_in;
         end
      end
   end

   assign prog  = prog_ff;
   assign alpha = q_ff;
   assign done  = done_ff;

endmodule

`default_nettype wire

// ===== src/loop_or_single_progress_timer_core.sv =====
// ----------------------------------------------------------------------------
// Loop or single progress timer core
// Millisecond progress timer with infinite, looping and single-shot modes.
// ----------------------------------------------------------------------------
// One request word carries an operation (update, reset, toggle pause, set
// pause, rewind, fast forward) and answers with exactly one response word:
// expired flag, pause state, total time, progression and a Q1.16 alpha.
// Items are handled one at a time. The accumulator is updated bit-serially,
// LSB first, for every op; a restoring divider then retires one quotient bit
// per cycle, for the remainder and then alpha in loop mode and for alpha alone
// in single mode; it is skipped in infinite mode, in the unused mode or with a
// zero duration.
// A finished response waits in an output register, so the next request word
// is taken while the previous response is still held.
// ----------------------------------------------------------------------------
`default_nettype none

`include "loop_or_single_progress_timer_core_macros.svh"

module loop_or_single_progress_timer_core import lspt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // now_ms, amount_ms, pause_value
   input  wire logic [OP_W-1:0]       req_tuser,   // op
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // expired, paused_now,
                                                   // elapsed_total, progression, alpha
   output logic                       rsp_tuser,   // result_valid
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [TIME_BITS-1:0]  csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ACC  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [TIME_BITS-1:0] dur_ff;
   logic                 seen_ff, paused_ff;
   logic                 exp_cand_ff, valid_ff, use_div_ff;

   logic                 rsp_tvalid_ff;
   logic                 o_expired_ff, o_paused_ff, o_valid_ff;
   logic [TIME_BITS-1:0] o_elapsed_ff, o_prog_ff;
   logic [ALPHA_W-1:0]   o_alpha_ff;

   logic                 req_fire, rsp_fire, out_load, mode_valid;
   logic [OP_W-1:0]      op;
   logic [TIME_BITS-1:0] now_ms, amount_ms;
   logic                 pause_value;

   acc_cmd_type          acc_cmd;
   div_cmd_type          div_cmd;
   logic [TIME_BITS-1:0] acc_value, div_prog, single_prog;
   logic [ALPHA_W-1:0]   div_alpha;
   logic                 acc_above, acc_done, div_done;

   // unpack the request word
   assign op          = req_tuser;
   assign now_ms      = req_tdata[TIME_BITS-1:0];
   assign amount_ms   = req_tdata[2*TIME_BITS-1:TIME_BITS];
   assign pause_value = req_tdata[2*TIME_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid_ff & rsp_tready;
   assign out_load   = (state_ff == S_OUT) & (~rsp_tvalid_ff | rsp_tready);
   assign csr_ready  = 1'b1;
   assign mode_valid = (mode_ff == MODE_LOOP) | (mode_ff == MODE_SINGLE);

   // build the accumulator pass for this op from the state before it
   always_comb begin
      acc_cmd.start     = req_fire;
      acc_cmd.kind      = ACC_KEEP;
      acc_cmd.use_delta = 1'b0;
      acc_cmd.load_prev = 1'b0;
      unique case (op)
         OP_UPDATE: begin
            // first or paused update adds nothing
            acc_cmd.kind      = (seen_ff & ~paused_ff) ? ACC_ADD : ACC_KEEP;
            acc_cmd.use_delta = 1'b1;
            acc_cmd.load_prev = 1'b1;
         end
         OP_RESET:  acc_cmd.kind = ACC_CLEAR;
         OP_REWIND: acc_cmd.kind = ACC_SUB;
         OP_FFWD:   acc_cmd.kind = ACC_ADD;
         default:   acc_cmd.kind = ACC_KEEP;
      endcase
   end

   // single mode clamps the total to the duration
   assign single_prog = acc_above ? dur_ff : acc_value;

   assign div_cmd.start     = (state_ff == S_ACC) & acc_done & use_div_ff;
   assign div_cmd.loop_mode = (mode_ff == MODE_LOOP);

   lspt_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .cmd       (acc_cmd),
      .now       (now_ms),
      .amount    (amount_ms),
      .dur       (dur_ff),
      .acc_value (acc_value),
      .above_dur (acc_above),
      .done      (acc_done)
   );

   lspt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .numer     (acc_value),
      .prog_init (single_prog),
      .dur       (dur_ff),
      .prog      (div_prog),
      .alpha     (div_alpha),
      .done      (div_done)
   );

   // sequencer: accumulate, divide if needed, hand the word to the output stage
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) state_in = S_ACC;
         S_ACC:  if (acc_done) state_in = use_div_ff ? S_DIV : S_OUT;
         S_DIV:  if (div_done) state_in = S_OUT;
         S_OUT:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_INFINITE;
         dur_ff        <= DUR_RESET;
         seen_ff       <= 1'b0;
         paused_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         exp_cand_ff   <= 1'b0;
         valid_ff      <= 1'b0;
         use_div_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODE:     mode_ff <= csr_data[MODE_W-1:0];
               CSR_DURATION: dur_ff  <= csr_data;
               default:      dur_ff  <= dur_ff;
            endcase
         end

         if (req_fire) begin
            // expired is possible only for an unpaused update in single mode
            exp_cand_ff <= (op == OP_UPDATE) & ~paused_ff & (mode_ff == MODE_SINGLE);
            valid_ff    <= mode_valid;
            use_div_ff  <= mode_valid & (dur_ff != '0);
            unique case (op)
               OP_UPDATE:   seen_ff   <= 1'b1;
               OP_RESET:    seen_ff   <= 1'b0;
               OP_TOGGLE:   paused_ff <= ~paused_ff;
               OP_SETPAUSE: paused_ff <= pause_value;
               default:     seen_ff   <= seen_ff;
            endcase
         end

         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // response payload: hold until taken
   always_ff @(posedge clock) begin
      if (out_load) begin
         o_expired_ff <= exp_cand_ff & acc_above;
         o_paused_ff  <= paused_ff;
         o_elapsed_ff <= acc_value;
         o_prog_ff    <= use_div_ff ? div_prog  : '0;
         o_alpha_ff   <= use_div_ff ? div_alpha : '0;
         o_valid_ff   <= valid_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = o_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({o_alpha_ff, o_prog_ff, o_elapsed_ff,
                                    o_paused_ff, o_expired_ff});

   `LSPT_ASSERT(a_acc_done_state, acc_done |-> (state_ff == S_ACC), "acc done outside acc state")
   `LSPT_ASSERT(a_div_done_state, div_done |-> (state_ff == S_DIV), "div done outside div state")
   `LSPT_ASSERT(a_alpha_range, rsp_tvalid_ff |-> (o_alpha_ff <= ALPHA_ONE), "alpha above one")
   `LSPT_ASSERT(a_invalid_zero, (rsp_tvalid_ff && !o_valid_ff) |-> ((o_prog_ff == '0) && (o_alpha_ff == '0)), "invalid result not zero")
   `LSPT_NEVER(a_expired_valid, rsp_tvalid_ff && o_expired_ff && !o_valid_ff, "expired without valid mode")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Progress timer core testbench
// Drives operation words into the timer, predicts each response word in a
// scoreboard, and compares every field of every response as it is accepted.
// ----------------------------------------------------------------------------
// A short directed run walks the special cases: first update, paused update,
// time wrap, accumulator saturation, rewind past zero, reset op, unused op
// codes, unused mode, zero duration and the duration extremes. Random words
// follow in segments, each with its own mode and duration written while the
// core is idle, and with an idle pattern on both channels that changes by thirds.
// ----------------------------------------------------------------------------

import lspt_pkg::*;

// one predicted response word, field order as on rsp_tdata, result_valid from rsp_tuser on top
typedef struct packed {
   logic                       result_valid;
   logic [ALPHA_W-1:0]         alpha;
   logic [TIME_BITS-1:0]       progression;
   logic [TIME_BITS-1:0]       elapsed_total;
   logic                       paused_now;
   logic                       expired;
} timer_view_type;

class progress_scoreboard;
   logic [MODE_W-1:0]    mode;
   logic [TIME_BITS-1:0] duration;
   logic                 seen_update;
   logic                 paused;
   logic [TIME_BITS-1:0] prev_time;
   logic [TIME_BITS-1:0] total;
   timer_view_type       expected_views[$];
   int unsigned          mismatches;

   function new();
      mode        = MODE_INFINITE;
      duration    = DUR_RESET;
      seen_update = 1'b0;
      paused      = 1'b0;
      prev_time   = '0;
      total       = '0;
      mismatches  = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] index, logic [TIME_BITS-1:0] value);
      if (index == CSR_MODE)
         mode = value[MODE_W-1:0];
      else
         duration = value;
   endfunction

   // add and clamp at all ones
   function logic [TIME_BITS-1:0] saturating_sum(logic [TIME_BITS-1:0] a,
                                                 logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
   endfunction

   function void predict_view(logic [OP_W-1:0] op, logic [TIME_BITS-1:0] now_ms,
                              logic [TIME_BITS-1:0] amount_ms, logic pause_value);
      timer_view_type       view;
      logic [TIME_BITS-1:0] prog;
      logic [63:0]          scaled;
      view = '0;
      case (op)
         OP_UPDATE: begin
            // first update only latches the time base
            if (!seen_update) begin
               prev_time   = now_ms;
               seen_update = 1'b1;
            end
            if (!paused) begin
               total = saturating_sum(total, now_ms - prev_time);
               if (mode == MODE_SINGLE)
                  view.expired = (total > duration);
            end
            prev_time = now_ms;
         end
         OP_RESET: begin
            seen_update = 1'b0;
            total       = '0;
         end
         OP_TOGGLE:   paused = !paused;
         OP_SETPAUSE: paused = pause_value;
         OP_REWIND:   total = (amount_ms >= total) ? '0 : total - amount_ms;
         OP_FFWD:     total = saturating_sum(total, amount_ms);
         default: ;
      endcase
      if (mode == MODE_LOOP || mode == MODE_SINGLE) begin
         view.result_valid = 1'b1;
         if (duration != 0) begin
            if (mode == MODE_LOOP)
               prog = total % duration;
            else
               prog = (total > duration) ? duration : total;
            scaled = ({32'd0, prog} << ALPHA_FRAC_BITS) / {32'd0, duration};
            view.progression = prog;
            view.alpha       = scaled[ALPHA_W-1:0];
         end
      end
      view.paused_now    = paused;
      view.elapsed_total = total;
      expected_views.push_back(view);
   endfunction

   function void check_field(string field, logic [TIME_BITS-1:0] want,
                             logic [TIME_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function void check_view(logic [RSP_DATA_W-1:0] data, logic user);
      timer_view_type want;
      if (expected_views.size() == 0) begin
         $display("%0t: response with nothing expected, expected none, actual %0h/%0b",
                  $time, data, user);
         mismatches++;
         return;
      end
      want = expected_views.pop_front();
      check_field("expired",       TIME_BITS'(want.expired),      TIME_BITS'(data[0]));
      check_field("paused_now",    TIME_BITS'(want.paused_now),   TIME_BITS'(data[1]));
      check_field("elapsed_total", want.elapsed_total, data[33:2]);
      check_field("progression",   want.progression,   data[65:34]);
      check_field("alpha",         TIME_BITS'(want.alpha),        TIME_BITS'(data[82:66]));
      check_field("result_valid",  TIME_BITS'(want.result_valid), TIME_BITS'(user));
   endfunction

   function int pending();
      return expected_views.size();
   endfunction
endclass

module testbench;

   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int SEGMENTS     = 9;
   localparam int SEGMENT_LEN  = 150;

   // op and mode codes the core does not define
   localparam logic [OP_W-1:0]   OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0]   OP_SPARE_B = 3'd7;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // now_ms, amount_ms, pause_value
   logic [OP_W-1:0]       req_tuser  = '0;   // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // expired, paused_now, elapsed_total,
                                             // progression, alpha
   logic                  rsp_tuser;         // result_valid
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [TIME_BITS-1:0]  csr_data   = '0;

   progress_scoreboard   progress_sb = new();
   int unsigned          send_idle_pct = 29;
   int unsigned          rsp_idle_pct  = 48;
   int unsigned          cycle_count   = 0;
   logic [TIME_BITS-1:0] period_ms     = DUR_RESET;   // duration the core runs with
   logic [TIME_BITS-1:0] wall_ms       = '0;          // time base, moved by each update

   loop_or_single_progress_timer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // stall the response side at random, per cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // predict on every accepted request word, check every accepted response word
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            progress_sb.predict_view(req_tuser, req_tdata[31:0], req_tdata[63:32],
                                     req_tdata[64]);
         if (rsp_tvalid && rsp_tready)
            progress_sb.check_view(rsp_tdata, rsp_tuser);
      end
   end

   // end the run if it hangs
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // present one request word and hold it until the core takes it
   task automatic push_word(input logic [OP_W-1:0] op, input logic [TIME_BITS-1:0] now_ms,
                            input logic [TIME_BITS-1:0] amount_ms, input logic pause_value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {7'd0, pause_value, amount_ms, now_ms};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // drop valid and wait until every response word is back
   task automatic drain();
      req_tvalid = 1'b0;
      while (progress_sb.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write one register; only called with the core idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [TIME_BITS-1:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      progress_sb.write_register(index, value);
      if (index == CSR_DURATION)
         period_ms = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_timer(input logic [MODE_W-1:0] mode, input logic [TIME_BITS-1:0] dur);
      drain();
      write_csr(CSR_MODE, TIME_BITS'(mode));
      write_csr(CSR_DURATION, dur);
   endtask

   // mostly updates on a moving time base, with the other ops mixed in
   task automatic push_random_item();
      logic [OP_W-1:0]      op;
      logic [TIME_BITS-1:0] now_ms;
      logic [TIME_BITS-1:0] amount_ms;
      logic [TIME_BITS-1:0] span;
      int unsigned          pick;
      span      = (period_ms == 0 || period_ms > 32'd50000) ? 32'd50000 : 2 * period_ms;
      now_ms    = $urandom;
      amount_ms = $urandom;
      pick      = $urandom_range(99);
      if (pick < 55) begin
         op = OP_UPDATE;
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: now_ms = wall_ms + $urandom_range(span);
            6, 7:             now_ms = wall_ms + $urandom_range(3);
            8:                now_ms = wall_ms + $urandom;    // big jump, may wrap
            default: ;                                        // unrelated time
         endcase
         wall_ms = now_ms;
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: amount_ms = $urandom_range(span);
            9:                   amount_ms = '1;
            default: ;
         endcase
         if (pick < 61)
            op = OP_RESET;
         else if (pick < 69)
            op = OP_TOGGLE;
         else if (pick < 77)
            op = OP_SETPAUSE;
         else if (pick < 87)
            op = OP_REWIND;
         else if (pick < 96)
            op = OP_FFWD;
         else
            op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      end
      push_word(op, now_ms, amount_ms, 1'($urandom));
   endtask

   initial begin
      logic [MODE_W-1:0]    seg_mode[SEGMENTS] = '{MODE_LOOP, MODE_SINGLE, MODE_LOOP,
                                                  MODE_INFINITE, MODE_SINGLE, MODE_LOOP,
                                                  MODE_SINGLE, MODE_SPARE, MODE_LOOP};
      logic [TIME_BITS-1:0] seg_dur;

      // hold reset, then release it on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset values: infinite mode, 1000 ms
      push_word(OP_UPDATE, 32'd100, 32'd0, 1'b0);           // first update
      push_word(OP_UPDATE, 32'd300, 32'd0, 1'b1);
      push_word(OP_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      push_word(OP_SPARE_B, 32'd0, 32'd0, 1'b0);

      // single shot: pause, expiry, rewind and saturation
      set_timer(MODE_SINGLE, 32'd1000);
      push_word(OP_UPDATE, 32'd1000, 32'd0, 1'b0);
      push_word(OP_UPDATE, 32'd1500, 32'd0, 1'b0);
      push_word(OP_TOGGLE, 32'd0, 32'd0, 1'b0);
      push_word(OP_UPDATE, 32'd2500, 32'd0, 1'b0);          // paused, nothing added
      push_word(OP_TOGGLE, 32'd0, 32'd0, 1'b0);
      push_word(OP_UPDATE, 32'd3200, 32'd0, 1'b0);          // past the end
      push_word(OP_SETPAUSE, 32'd0, 32'd0, 1'b1);
      push_word(OP_SETPAUSE, 32'd0, 32'd0, 1'b0);
      push_word(OP_REWIND, 32'd0, 32'd100, 1'b0);
      push_word(OP_REWIND, 32'd0, 32'hFFFF_FFFF, 1'b0);     // clamps at zero
      push_word(OP_FFWD, 32'd0, 32'hFFFF_FFF0, 1'b0);
      push_word(OP_FFWD, 32'd0, 32'hFFFF_FFFF, 1'b0);       // saturates
      push_word(OP_RESET, 32'd0, 32'd0, 1'b0);
      push_word(OP_UPDATE, 32'hFFFF_FFF0, 32'd0, 1'b0);
      push_word(OP_UPDATE, 32'h0000_0010, 32'd0, 1'b0);     // time wraps

      // looping at both duration extremes
      set_timer(MODE_LOOP, 32'd1);
      push_word(OP_FFWD, 32'd0, 32'd12345, 1'b0);
      set_timer(MODE_LOOP, 32'hFFFF_FFFF);
      push_word(OP_FFWD, 32'd0, 32'hFFFF_FFFF, 1'b0);
      push_word(OP_REWIND, 32'd0, 32'd1, 1'b0);

      // zero duration, then the unused mode
      set_timer(MODE_SINGLE, 32'd0);
      push_word(OP_UPDATE, 32'h0000_0020, 32'd0, 1'b0);
      set_timer(MODE_SPARE, 32'd500);
      push_word(OP_UPDATE, 32'h0000_0040, 32'd0, 1'b0);

      // random segments: a new setting each, idle pattern by thirds
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(9))
            6:       seg_dur = 32'd1;
            7:       seg_dur = 32'hFFFF_FFFF;
            8:       seg_dur = $urandom;
            default: seg_dur = $urandom_range(1, 2000);
         endcase
         set_timer(seg_mode[seg], seg_dur);
         if (seg < 3) begin
            send_idle_pct = 29;
            rsp_idle_pct  = 48;
         end else if (seg < 6) begin
            send_idle_pct = 48;
            rsp_idle_pct  = 29;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         for (int n = 0; n < SEGMENT_LEN; n++)
            push_random_item();
      end

      // let the last responses come back, then settle
      drain();
      repeat (100) @(posedge clock);
      if (progress_sb.mismatches == 0 && progress_sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
